// ----- design/bmpt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_pkg
// Shared types and constants of the bitmap threshold blit unit.
// ----------------------------------------------------------------------------
package bmpt_pkg;

  localparam int SCREEN_WIDTH_DEFAULT  = 84;
  localparam int SCREEN_HEIGHT_DEFAULT = 48;

  // frame buffer address field, wide enough for the largest screen
  localparam int BUF_ADDR_W = 13;
  localparam int COL_W      = 9;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int OPQ_DEPTH  = 4;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [3:0] THR_MAX     = 4'd14;
  localparam logic [7:0] MASK_TOP    = 8'h80;
  localparam logic [7:0] MASK_BOTTOM = 8'h01;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_DISCARD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_RESULT = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_READ   = 2'd2
  } op_kind_t;

  typedef enum logic [2:0] {
    REG_IMAGE_X      = 3'd0,
    REG_IMAGE_Y      = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_THRESHOLD    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] image_x;
    logic [5:0] image_y;
    logic [7:0] image_width;
    logic [7:0] image_height;
    logic [3:0] pixel_threshold;
  } cfg_t;

  typedef struct packed {
    op_kind_t              kind;
    status_t               status;
    logic                  done;
    logic                  wr0;
    logic                  wr1;
    logic                  set0;
    logic                  set1;
    logic [7:0]            mask;
    logic [BUF_ADDR_W-1:0] addr0;
    logic [BUF_ADDR_W-1:0] addr1;
  } op_t;

  typedef struct packed {
    logic [7:0] read_data;
    status_t    status;
    logic       image_done;
  } res_t;

endpackage
`default_nettype wire

// ----- design/bmpt_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_if
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
interface bmpt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic [8:0] buffer_index;

  modport source(output valid, command, data_byte, buffer_index, input ready);
  modport sink(input valid, command, data_byte, buffer_index, output ready);
endinterface

interface bmpt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] status;
  logic       image_done;

  modport source(output valid, read_data, status, image_done, input ready);
  modport sink(input valid, read_data, status, image_done, output ready);
endinterface
`default_nettype wire

// ----- design/bmpt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bmpt_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 504,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- design/bmpt_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_fifo
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
module bmpt_fifo #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o,
  output logic [CNT_W-1:0] count_o
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_r[head_r];
  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign count_o = count_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[tail_r] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/bmpt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_front
// Command decode and blit walker: clip check, row and page stepping,
// pixel thresholding and buffer address generation.
// ----------------------------------------------------------------------------
module bmpt_front #(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bmpt_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [1:0]    command_i,
  input  logic [7:0]    data_byte_i,
  input  logic [8:0]    buffer_index_i,
  output bmpt_pkg::op_t op_o
);

  import bmpt_pkg::*;

  localparam int BUF_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int IDX_W     = $clog2(7 * SCREEN_WIDTH + (1 << COL_W) + 1);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [2:0]       page_r, page_nxt;
  logic [7:0]       mask_r, mask_nxt;
  logic [6:0]       bytes_r, bytes_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [7:0]       rows_r, rows_nxt;
  logic             active_r, active_nxt;

  logic [8:0]       xw_sum;
  logic [7:0]       y_plus;
  logic             reject;
  logic [3:0]       thr;
  logic [COL_W-1:0] col1;
  logic [IDX_W-1:0] base, idx0, idx1;
  logic             wr0, wr1;
  logic [6:0]       half_w;
  logic [6:0]       bytes_dec;
  logic [7:0]       rows_dec;

  assign xw_sum = {2'b00, cfg_i.image_x} + {1'b0, cfg_i.image_width};
  assign y_plus = {2'b00, cfg_i.image_y} + 8'd1;
  assign reject = (cfg_i.image_height == 8'd0) || cfg_i.image_width[0] ||
                  (int'(xw_sum) > SCREEN_WIDTH) || (y_plus < cfg_i.image_height) ||
                  (int'(cfg_i.image_y) >= SCREEN_HEIGHT);
  assign thr    = (cfg_i.pixel_threshold > THR_MAX) ? THR_MAX : cfg_i.pixel_threshold;
  assign half_w = cfg_i.image_width[7:1];

  assign col1 = col_r + 1'b1;
  assign base = IDX_W'(page_r) * IDX_W'(SCREEN_WIDTH);
  assign idx0 = base + IDX_W'(col_r);
  assign idx1 = base + IDX_W'(col1);
  assign wr0  = (int'(col_r) < SCREEN_WIDTH) && (int'(idx0) < BUF_BYTES);
  assign wr1  = (int'(col1) < SCREEN_WIDTH) && (int'(idx1) < BUF_BYTES);

  assign bytes_dec = (bytes_r != 7'd0) ? bytes_r - 1'b1 : 7'd0;
  assign rows_dec  = (rows_r != 8'd0) ? rows_r - 1'b1 : 8'd0;

  always_comb begin
    col_nxt    = col_r;
    page_nxt   = page_r;
    mask_nxt   = mask_r;
    bytes_nxt  = bytes_r;
    pad_nxt    = pad_r;
    rows_nxt   = rows_r;
    active_nxt = active_r;
    op_o        = '0;
    op_o.kind   = OP_RESULT;
    op_o.status = ST_OK;
    case (cmd_t'(command_i))
      CMD_START: begin
        if (reject) begin
          op_o.status = ST_REJECT;
          active_nxt  = 1'b0;
        end else begin
          page_nxt   = cfg_i.image_y[5:3];
          mask_nxt   = MASK_BOTTOM << cfg_i.image_y[2:0];
          col_nxt    = COL_W'(cfg_i.image_x);
          bytes_nxt  = half_w;
          rows_nxt   = cfg_i.image_height;
          pad_nxt    = 2'd0;
          active_nxt = (cfg_i.image_width != 8'd0);
        end
      end
      CMD_DATA: begin
        if (!active_r) begin
          op_o.status = ST_DISCARD;
        end else if (pad_r != 2'd0) begin
          pad_nxt = pad_r - 1'b1;
        end else begin
          op_o.kind  = OP_PIXEL;
          op_o.wr0   = wr0;
          op_o.wr1   = wr1;
          op_o.set0  = (data_byte_i[7:4] > thr);
          op_o.set1  = (data_byte_i[3:0] > thr);
          op_o.mask  = mask_r;
          op_o.addr0 = BUF_ADDR_W'(idx0);
          op_o.addr1 = BUF_ADDR_W'(idx1);
          col_nxt    = col_r + COL_W'(2);
          bytes_nxt  = bytes_dec;
          if (bytes_dec == 7'd0) begin
            rows_nxt = rows_dec;
            if (rows_dec == 8'd0) begin
              active_nxt = 1'b0;
              op_o.done  = 1'b1;
            end else begin
              if (mask_r > MASK_BOTTOM) begin
                mask_nxt = mask_r >> 1;
              end else begin
                mask_nxt = MASK_TOP;
                page_nxt = (page_r == 3'd0) ? 3'd0 : page_r - 1'b1;
              end
              col_nxt   = COL_W'(cfg_i.image_x);
              bytes_nxt = half_w;
              pad_nxt   = 2'd0 - half_w[1:0];
              if (half_w == 7'd0) begin
                active_nxt = 1'b0;
                op_o.done  = 1'b1;
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (int'(buffer_index_i) < BUF_BYTES) begin
          op_o.kind  = OP_READ;
          op_o.addr0 = BUF_ADDR_W'(buffer_index_i);
        end else begin
          op_o.status = ST_DISCARD;
        end
      end
      default: begin
        op_o.status = ST_DISCARD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      page_r   <= '0;
      mask_r   <= MASK_BOTTOM;
      bytes_r  <= '0;
      pad_r    <= '0;
      rows_r   <= '0;
      active_r <= 1'b0;
    end else if (accept_i) begin
      col_r    <= col_nxt;
      page_r   <= page_nxt;
      mask_r   <= mask_nxt;
      bytes_r  <= bytes_nxt;
      pad_r    <= pad_nxt;
      rows_r   <= rows_nxt;
      active_r <= active_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/bmpt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_back
// Frame buffer engine: clearing sweep, per-pixel read-modify-write with
// write bypass, buffer reads and the result queue.
// ----------------------------------------------------------------------------
module bmpt_back #(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bmpt_pkg::op_t  head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  output logic           clr_busy_o,
  bmpt_out_if.source     out_ch
);

  import bmpt_pkg::*;

  localparam int BUF_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int ADDR_W    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int CNT_W     = $clog2(OUTQ_DEPTH + 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(BUF_BYTES - 1);

  typedef struct packed {
    logic              rmw;
    logic              rd;
    logic              res;
    logic              set;
    logic [7:0]        mask;
    logic [ADDR_W-1:0] addr;
    status_t           status;
    logic              done;
  } uop_t;

  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              phase_r, phase_nxt;
  logic              ex_valid_r;
  uop_t              ex_r;
  uop_t              uop;
  logic              wb_valid_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic [7:0]        wb_data_r;

  logic              issue;
  logic              room;
  logic              ex_we;
  logic [7:0]        ram_rdata;
  logic [7:0]        data_cur;
  logic [7:0]        data_new;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  logic              outq_push;
  logic              outq_empty;
  logic              outq_full;
  logic [CNT_W-1:0]  outq_count;
  res_t              outq_din;
  res_t              outq_dout;

  // micro-op selection; a pixel transaction is two micro-ops
  always_comb begin
    uop        = '0;
    uop.status = head_i.status;
    uop.done   = head_i.done;
    case (head_i.kind)
      OP_PIXEL: begin
        uop.mask = head_i.mask;
        if (phase_r) begin
          uop.rmw  = head_i.wr1;
          uop.set  = head_i.set1;
          uop.addr = ADDR_W'(head_i.addr1);
          uop.res  = 1'b1;
        end else begin
          uop.rmw  = head_i.wr0;
          uop.set  = head_i.set0;
          uop.addr = ADDR_W'(head_i.addr0);
          uop.done = 1'b0;
        end
      end
      OP_READ: begin
        uop.rd   = 1'b1;
        uop.res  = 1'b1;
        uop.addr = ADDR_W'(head_i.addr0);
      end
      default: begin
        uop.res = 1'b1;
      end
    endcase
  end

  assign room  = ({1'b0, outq_count} + (CNT_W + 1)'(ex_valid_r && ex_r.res))
                 < (CNT_W + 1)'(OUTQ_DEPTH);
  assign issue = head_valid_i && !clr_busy_r && room;
  assign pop_o = issue && ((head_i.kind != OP_PIXEL) || phase_r);
  assign phase_nxt = (issue && (head_i.kind == OP_PIXEL)) ? !phase_r : phase_r;
  assign clr_busy_o = clr_busy_r;

  // bypass the write that landed in the same cycle as this read
  assign data_cur = (wb_valid_r && (wb_addr_r == ex_r.addr)) ? wb_data_r : ram_rdata;
  assign data_new = ex_r.set ? (data_cur | ex_r.mask) : (data_cur & ~ex_r.mask);
  assign ex_we    = ex_valid_r && ex_r.rmw;

  assign ram_we    = clr_busy_r || ex_we;
  assign ram_waddr = clr_busy_r ? clr_addr_r : ex_r.addr;
  assign ram_wdata = clr_busy_r ? 8'd0 : data_new;

  bmpt_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_ram (
    .clk     (clk),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (uop.addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      phase_r    <= 1'b0;
      ex_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_addr_r == ADDR_LAST) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
      phase_r    <= phase_nxt;
      ex_valid_r <= issue;
      wb_valid_r <= ex_we;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ex_r <= uop;
    end
    wb_addr_r <= ex_r.addr;
    wb_data_r <= data_new;
  end

  assign outq_push            = ex_valid_r && ex_r.res;
  assign outq_din.read_data   = ex_r.rd ? data_cur : 8'd0;
  assign outq_din.status      = ex_r.status;
  assign outq_din.image_done  = ex_r.done;

  bmpt_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (outq_push),
    .data_i  (outq_din),
    .pop_i   (out_ch.ready),
    .data_o  (outq_dout),
    .empty_o (outq_empty),
    .full_o  (outq_full),
    .count_o (outq_count)
  );

  assign out_ch.valid      = !outq_empty;
  assign out_ch.read_data  = outq_dout.read_data;
  assign out_ch.status     = outq_dout.status;
  assign out_ch.image_done = outq_dout.image_done;

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    outq_push |-> !outq_full)
    else $error("result pushed into a full result queue");

  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !issue)
    else $error("micro-op issued during buffer clear");

  a_phase_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head_valid_i && (head_i.kind == OP_PIXEL)))
    else $error("second pixel phase without a pixel transaction at the head");

endmodule
`default_nettype wire

// ----- design/bitmap_threshold_to_page_buffer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_threshold_to_page_buffer_unit
// 4bpp bitmap threshold blit into a page-organized monochrome frame buffer.
// ----------------------------------------------------------------------------
// flow: a transaction is queued, issued as micro-ops that read the buffer, and
//   answered through the result queue; issue waits for room in that queue
// micro-ops: a data byte that draws takes one buffer read-modify-write per pixel
//   on the single write port, all other transactions take one micro-op
// reset: the frame buffer is swept to zero one byte per cycle over all
//   SCREEN_WIDTH*SCREEN_HEIGHT/8 bytes (504 by default); in_ch.ready is low
//   meanwhile, configuration writes are taken throughout
module bitmap_threshold_to_page_buffer_unit #(
  parameter int SCREEN_WIDTH  = bmpt_pkg::SCREEN_WIDTH_DEFAULT,
  parameter int SCREEN_HEIGHT = bmpt_pkg::SCREEN_HEIGHT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bmpt_in_if.sink                         in_ch,
  bmpt_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bmpt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bmpt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bmpt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  import bmpt_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     accept;
  logic     clr_busy;
  op_t      front_op;
  op_t      head_op;
  logic     opq_empty;
  logic     opq_full;
  logic     opq_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_X:      cfg_r.image_x         <= cfg_pwdata[6:0];
        REG_IMAGE_Y:      cfg_r.image_y         <= cfg_pwdata[5:0];
        REG_IMAGE_WIDTH:  cfg_r.image_width     <= cfg_pwdata[7:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height    <= cfg_pwdata[7:0];
        REG_THRESHOLD:    cfg_r.pixel_threshold <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_X:      cfg_prdata = CFG_DATA_W'(cfg_r.image_x);
      REG_IMAGE_Y:      cfg_prdata = CFG_DATA_W'(cfg_r.image_y);
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DATA_W'(cfg_r.image_height);
      REG_THRESHOLD:    cfg_prdata = CFG_DATA_W'(cfg_r.pixel_threshold);
      default:          cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready = !opq_full && !clr_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  bmpt_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg_r),
    .accept_i       (accept),
    .command_i      (in_ch.command),
    .data_byte_i    (in_ch.data_byte),
    .buffer_index_i (in_ch.buffer_index),
    .op_o           (front_op)
  );

  bmpt_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(OPQ_DEPTH)
  ) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (accept),
    .data_i  (front_op),
    .pop_i   (opq_pop),
    .data_o  (head_op),
    .empty_o (opq_empty),
    .full_o  (opq_full),
    .count_o ()
  );

  bmpt_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head_op),
    .head_valid_i (!opq_empty),
    .pop_o        (opq_pop),
    .clr_busy_o   (clr_busy),
    .out_ch       (out_ch)
  );

endmodule
`default_nettype wire
